### hdl/gaps_pkg.sv
// Shared types, codes and step tables of the grid path search unit.
package gaps_pkg;

    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef logic [1:0] t_status;
    localparam t_status ST_UNVISITED = 2'd0;
    localparam t_status ST_OPEN      = 2'd1;
    localparam t_status ST_CLOSED    = 2'd2;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DIAG   = 3'd0;
    localparam t_cfg_idx CFG_SCOST  = 3'd1;
    localparam t_cfg_idx CFG_DCOST  = 3'd2;
    localparam t_cfg_idx CFG_WEIGHT = 3'd3;
    localparam t_cfg_idx CFG_COLS   = 3'd4;
    localparam t_cfg_idx CFG_ROWS   = 3'd5;

    localparam logic [15:0] COST_MAX = 16'hFFFF;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_WR, S_PRD, S_PRD2, S_CHK, S_CLR, S_SEED,
        S_SA, S_SB, S_SC, S_SEL, S_NA, S_NB,
        S_CNT, S_CNT2, S_ST, S_ST2, S_DONE
    } t_state;

    function automatic logic [1:0] step_dx(logic [2:0] d);
        case (d)
            3'd0, 3'd6, 3'd7: step_dx = 2'b01;
            3'd1, 3'd4, 3'd5: step_dx = 2'b11;
            default:          step_dx = 2'b00;
        endcase
    endfunction

    function automatic logic [1:0] step_dy(logic [2:0] d);
        case (d)
            3'd2, 3'd5, 3'd7: step_dy = 2'b01;
            3'd3, 3'd4, 3'd6: step_dy = 2'b11;
            default:          step_dy = 2'b00;
        endcase
    endfunction

    function automatic logic [8:0] clamp_dim(logic [5:0] v, int unsigned maxv);
        if (v == 6'd0) begin
            clamp_dim = 9'd1;
        end else if (32'(v) > maxv) begin
            clamp_dim = 9'(maxv);
        end else begin
            clamp_dim = 9'(v);
        end
    endfunction

endpackage

### hdl/gaps_ram.sv
// Single-port-write, single-port-read memory with registered read data.
module gaps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/gaps_fcalc.sv
// Shared score unit: path cost plus weighted distance, product registered.
module gaps_fcalc (
    input  logic        i_clk,
    input  logic [15:0] i_cost,
    input  logic [7:0]  i_weight,
    input  logic [8:0]  i_dist,
    output logic [17:0] o_score,
    output logic [15:0] o_cost
);

    logic [16:0] r_prod;
    logic [15:0] r_cost;

    always_ff @(posedge i_clk) begin
        r_prod <= 17'(i_weight) * 17'(i_dist);
        r_cost <= i_cost;
    end

    assign o_score = 18'(r_cost) + 18'(r_prod);
    assign o_cost  = r_cost;

endmodule

### hdl/grid_a_star_path_search_unit.sv
// Grid A* path search unit: cell writes, searches and path reads over one word channel.
// One input word is taken at a time. A path read takes a shorter route when the index
// lies past the stored path.
// A search first clears the cell status memory, then loops: a scan of every cell of
// the grid in use through the shared score unit, then a check of each neighbour of
// the chosen cell; the path is walked back twice. After reset the blocked map and
// status memory are swept before the first word is taken.
module grid_a_star_path_search_unit
    import gaps_pkg::*;
#(
    parameter int MAX_COLUMNS = 32,
    parameter int MAX_ROWS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [4:0]  i_cell_col,
    input  logic [4:0]  i_cell_row,
    input  logic        i_blocked,
    input  logic [4:0]  i_start_x,
    input  logic [4:0]  i_start_y,
    input  logic [4:0]  i_goal_x,
    input  logic [4:0]  i_goal_y,
    input  logic [9:0]  i_path_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [10:0] o_path_length,
    output logic        o_entry_valid,
    output logic [4:0]  o_entry_col,
    output logic [4:0]  o_entry_row,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int IDXW  = $clog2(CELLS);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int NW    = $clog2(CELLS + 1);

    t_state r_state, n_state;

    logic       r_diag;
    logic [7:0] r_scost, r_dcost, r_weight;
    logic [5:0] r_gcols, r_grows;

    logic [4:0] r_cc, r_cr, r_sx, r_sy, r_gx, r_gy;
    logic       r_blk;
    logic [9:0] r_pi;

    logic [IDXW-1:0] r_ptr;
    logic [CW-1:0]   r_c, r_bc, r_nc, r_cur_c;
    logic [RW-1:0]   r_r, r_br, r_nr, r_cur_r;
    logic            r_have, r_sopen;
    logic [17:0]     r_bf;
    logic [15:0]     r_bg;
    logic [3:0]      r_d;
    logic [NW-1:0]   r_n, r_k, r_plen;
    logic            r_found;
    logic            r_ev;
    logic [4:0]      r_ecol, r_erow;

    logic        r_ovalid, r_ofound, r_oev;
    logic [10:0] r_oplen;
    logic [4:0]  r_oecol, r_oerow;

    logic [8:0] w_cols, w_rows;
    logic [8:0] w_dc, w_dr, w_dist;
    logic       w_scan_last;
    logic       w_at_goal, w_at_start, w_oob, w_in_store;
    logic [2:0] w_d3;
    logic [1:0] w_dx, w_dy, w_pdx, w_pdy;
    logic [9:0] w_nx, w_ny;
    logic       w_nout;
    logic [3:0] w_dirs;
    logic [16:0] w_gsum;
    logic [15:0] w_g;
    logic        w_relax;
    logic [CW-1:0] w_pc;
    logic [RW-1:0] w_pr;
    logic [17:0] w_score;
    logic [15:0] w_scost_g;

    logic            blk_we, blk_wd, blk_rd;
    logic [IDXW-1:0] blk_wa, blk_ra;
    logic            st_we;
    t_status         st_wd, st_rd;
    logic [IDXW-1:0] st_wa, st_ra;
    logic            cost_we;
    logic [15:0]     cost_wd, cost_rd;
    logic [IDXW-1:0] cost_wa, cost_ra;
    logic            par_we;
    logic [2:0]      par_wd, par_rd;
    logic [IDXW-1:0] par_wa, par_ra;
    logic            path_we;
    logic [RW+CW-1:0] path_wd, path_rd;
    logic [IDXW-1:0] path_wa, path_ra;

    function automatic logic [IDXW-1:0] cell_addr(logic [31:0] row, logic [31:0] col);
        cell_addr = IDXW'(row * MAX_COLUMNS + col);
    endfunction

    assign w_cols = clamp_dim(r_gcols, MAX_COLUMNS);
    assign w_rows = clamp_dim(r_grows, MAX_ROWS);

    assign w_dc   = (9'(r_c) >= 9'(r_gx)) ? 9'(r_c) - 9'(r_gx) : 9'(r_gx) - 9'(r_c);
    assign w_dr   = (9'(r_r) >= 9'(r_gy)) ? 9'(r_r) - 9'(r_gy) : 9'(r_gy) - 9'(r_r);
    assign w_dist = w_dc + w_dr;
    assign w_scan_last = (9'(r_c) == w_cols - 9'd1) && (9'(r_r) == w_rows - 9'd1);

    assign w_at_goal  = (9'(r_bc) == 9'(r_gx)) && (9'(r_br) == 9'(r_gy));
    assign w_at_start = (9'(r_cur_c) == 9'(r_sx)) && (9'(r_cur_r) == 9'(r_sy));
    assign w_oob      = (9'(r_sx) >= w_cols) || (9'(r_sy) >= w_rows) ||
                        (9'(r_gx) >= w_cols) || (9'(r_gy) >= w_rows);
    assign w_in_store = (32'(r_cc) < MAX_COLUMNS) && (32'(r_cr) < MAX_ROWS);

    assign w_d3   = r_d[2:0];
    assign w_dx   = step_dx(w_d3);
    assign w_dy   = step_dy(w_d3);
    assign w_nx   = 10'(r_bc) + {{8{w_dx[1]}}, w_dx};
    assign w_ny   = 10'(r_br) + {{8{w_dy[1]}}, w_dy};
    assign w_nout = w_nx[9] || w_ny[9] || (w_nx[8:0] >= w_cols) || (w_ny[8:0] >= w_rows);
    assign w_dirs = r_diag ? 4'd8 : 4'd4;

    assign w_gsum = 17'(r_bg) + 17'((r_d < 4'd4) ? r_scost : r_dcost);
    assign w_g    = w_gsum[16] ? COST_MAX : w_gsum[15:0];
    assign w_relax = !blk_rd && (st_rd != ST_CLOSED) &&
                     ((st_rd == ST_UNVISITED) || (w_g < cost_rd));

    assign w_pdx = step_dx(par_rd);
    assign w_pdy = step_dy(par_rd);
    assign w_pc  = CW'(10'(r_cur_c) - {{8{w_pdx[1]}}, w_pdx});
    assign w_pr  = RW'(10'(r_cur_r) - {{8{w_pdy[1]}}, w_pdy});

    gaps_fcalc u_fcalc (
        .i_clk    (i_clk),
        .i_cost   (cost_rd),
        .i_weight (r_weight),
        .i_dist   (w_dist),
        .o_score  (w_score),
        .o_cost   (w_scost_g)
    );

    gaps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_blk (
        .i_clk(i_clk), .i_we(blk_we), .i_waddr(blk_wa), .i_wdata(blk_wd),
        .i_raddr(blk_ra), .o_rdata(blk_rd)
    );
    gaps_ram #(.WIDTH(2), .DEPTH(CELLS)) u_status (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_wa), .i_wdata(st_wd),
        .i_raddr(st_ra), .o_rdata(st_rd)
    );
    gaps_ram #(.WIDTH(16), .DEPTH(CELLS)) u_cost (
        .i_clk(i_clk), .i_we(cost_we), .i_waddr(cost_wa), .i_wdata(cost_wd),
        .i_raddr(cost_ra), .o_rdata(cost_rd)
    );
    gaps_ram #(.WIDTH(3), .DEPTH(CELLS)) u_parent (
        .i_clk(i_clk), .i_we(par_we), .i_waddr(par_wa), .i_wdata(par_wd),
        .i_raddr(par_ra), .o_rdata(par_rd)
    );
    gaps_ram #(.WIDTH(RW + CW), .DEPTH(CELLS)) u_path (
        .i_clk(i_clk), .i_we(path_we), .i_waddr(path_wa), .i_wdata(path_wd),
        .i_raddr(path_ra), .o_rdata(path_rd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (32'(r_ptr) == CELLS - 1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    case (t_mode'(i_mode))
                        MODE_WRITE:  n_state = S_WR;
                        MODE_SEARCH: n_state = S_CHK;
                        MODE_READ:   n_state = S_PRD;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_WR:   n_state = S_DONE;
            S_PRD:  n_state = (32'(r_pi) < 32'(r_plen)) ? S_PRD2 : S_DONE;
            S_PRD2: n_state = S_DONE;
            S_CHK:  n_state = w_oob ? S_DONE : S_CLR;
            S_CLR: begin
                if (32'(r_ptr) == CELLS - 1) n_state = S_SEED;
            end
            S_SEED: n_state = S_SA;
            S_SA:   n_state = S_SB;
            S_SB:   n_state = S_SC;
            S_SC:   n_state = w_scan_last ? S_SEL : S_SA;
            S_SEL: begin
                if (!r_have) n_state = S_DONE;
                else if (w_at_goal) n_state = S_CNT;
                else n_state = S_NA;
            end
            S_NA: begin
                if (r_d >= w_dirs) n_state = S_SA;
                else if (!w_nout) n_state = S_NB;
            end
            S_NB:   n_state = S_NA;
            S_CNT:  n_state = (w_at_start || 32'(r_n) >= CELLS) ? S_ST : S_CNT2;
            S_CNT2: n_state = S_CNT;
            S_ST:   n_state = S_ST2;
            S_ST2:  n_state = (r_k == '0) ? S_DONE : S_ST;
            S_DONE: begin
                if (!r_ovalid) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        blk_we = 1'b0; blk_wa = '0; blk_wd = 1'b0; blk_ra = '0;
        st_we = 1'b0; st_wa = '0; st_wd = ST_UNVISITED; st_ra = '0;
        cost_we = 1'b0; cost_wa = '0; cost_wd = '0; cost_ra = '0;
        par_we = 1'b0; par_wa = '0; par_wd = '0; par_ra = '0;
        path_we = 1'b0; path_wa = '0; path_wd = '0; path_ra = '0;
        case (r_state)
            S_INIT: begin
                blk_we = 1'b1; blk_wa = r_ptr;
                st_we  = 1'b1; st_wa  = r_ptr;
            end
            S_WR: begin
                blk_we = w_in_store;
                blk_wa = cell_addr(32'(r_cr), 32'(r_cc));
                blk_wd = r_blk;
            end
            S_PRD: path_ra = IDXW'(r_pi);
            S_CLR: begin
                st_we = 1'b1; st_wa = r_ptr;
            end
            S_SEED: begin
                st_we   = 1'b1; st_wa   = cell_addr(32'(r_sy), 32'(r_sx)); st_wd = ST_OPEN;
                cost_we = 1'b1; cost_wa = cell_addr(32'(r_sy), 32'(r_sx));
                par_we  = 1'b1; par_wa  = cell_addr(32'(r_sy), 32'(r_sx));
            end
            S_SA: begin
                st_ra   = cell_addr(32'(r_r), 32'(r_c));
                cost_ra = cell_addr(32'(r_r), 32'(r_c));
            end
            S_SEL: begin
                st_we = r_have; st_wa = cell_addr(32'(r_br), 32'(r_bc)); st_wd = ST_CLOSED;
            end
            S_NA: begin
                blk_ra  = cell_addr(32'(w_ny), 32'(w_nx));
                st_ra   = cell_addr(32'(w_ny), 32'(w_nx));
                cost_ra = cell_addr(32'(w_ny), 32'(w_nx));
            end
            S_NB: begin
                st_we   = w_relax; st_wa   = cell_addr(32'(r_nr), 32'(r_nc)); st_wd = ST_OPEN;
                cost_we = w_relax; cost_wa = cell_addr(32'(r_nr), 32'(r_nc)); cost_wd = w_g;
                par_we  = w_relax; par_wa  = cell_addr(32'(r_nr), 32'(r_nc)); par_wd = w_d3;
            end
            S_CNT, S_ST: par_ra = cell_addr(32'(r_cur_r), 32'(r_cur_c));
            S_ST2: begin
                path_we = 1'b1; path_wa = IDXW'(r_k); path_wd = {r_cur_r, r_cur_c};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_ptr    <= '0;
            r_diag   <= 1'b0;
            r_scost  <= 8'd10;
            r_dcost  <= 8'd14;
            r_weight <= 8'd10;
            r_gcols  <= 6'd32;
            r_grows  <= 6'd32;
            r_found  <= 1'b0;
            r_plen   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DIAG:   r_diag   <= i_cfg_data[0];
                    CFG_SCOST:  r_scost  <= i_cfg_data;
                    CFG_DCOST:  r_dcost  <= i_cfg_data;
                    CFG_WEIGHT: r_weight <= i_cfg_data;
                    CFG_COLS:   r_gcols  <= i_cfg_data[5:0];
                    CFG_ROWS:   r_grows  <= i_cfg_data[5:0];
                    default: begin
                    end
                endcase
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_INIT, S_CLR: r_ptr <= r_ptr + 1'b1;
                S_CHK: begin
                    r_found <= 1'b0;
                    r_plen  <= '0;
                    r_ptr   <= '0;
                end
                S_ST2: begin
                    if (r_k == '0) begin
                        r_found <= 1'b1;
                        r_plen  <= r_n;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid) r_ovalid <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cc <= i_cell_col; r_cr <= i_cell_row; r_blk <= i_blocked;
                r_sx <= i_start_x;  r_sy <= i_start_y;
                r_gx <= i_goal_x;   r_gy <= i_goal_y;
                r_pi <= i_path_index;
                r_ev <= 1'b0; r_ecol <= '0; r_erow <= '0;
            end
            S_PRD2: begin
                r_ev   <= 1'b1;
                r_ecol <= 5'(path_rd[CW-1:0]);
                r_erow <= 5'(path_rd[RW+CW-1:CW]);
            end
            S_SEED: begin
                r_c <= '0; r_r <= '0; r_have <= 1'b0;
            end
            S_SB: r_sopen <= (st_rd == ST_OPEN);
            S_SC: begin
                if (r_sopen && (!r_have || w_score < r_bf)) begin
                    r_have <= 1'b1;
                    r_bf <= w_score; r_bg <= w_scost_g;
                    r_bc <= r_c; r_br <= r_r;
                end
                if (9'(r_c) == w_cols - 9'd1) begin
                    r_c <= '0;
                    r_r <= r_r + 1'b1;
                end else begin
                    r_c <= r_c + 1'b1;
                end
            end
            S_SEL: begin
                r_d <= '0;
                r_cur_c <= CW'(r_gx); r_cur_r <= RW'(r_gy);
                r_n <= NW'(1);
            end
            S_NA: begin
                if (r_d >= w_dirs) begin
                    r_c <= '0; r_r <= '0; r_have <= 1'b0;
                end else if (w_nout) begin
                    r_d <= r_d + 4'd1;
                end else begin
                    r_nc <= CW'(w_nx); r_nr <= RW'(w_ny);
                end
            end
            S_NB: r_d <= r_d + 4'd1;
            S_CNT: begin
                if (w_at_start || 32'(r_n) >= CELLS) begin
                    r_k <= r_n - 1'b1;
                    r_cur_c <= CW'(r_gx); r_cur_r <= RW'(r_gy);
                end
            end
            S_CNT2: begin
                r_cur_c <= w_pc; r_cur_r <= w_pr;
                r_n <= r_n + 1'b1;
            end
            S_ST2: begin
                if (r_k != '0) begin
                    r_cur_c <= w_pc; r_cur_r <= w_pr;
                    r_k <= r_k - 1'b1;
                end
            end
            S_DONE: begin
                if (!r_ovalid) begin
                    r_ofound <= r_found;
                    r_oplen  <= 11'(r_plen);
                    r_oev    <= r_ev;
                    r_oecol  <= r_ecol;
                    r_oerow  <= r_erow;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_ovalid;
    assign o_found       = r_ofound;
    assign o_path_length = r_oplen;
    assign o_entry_valid = r_oev;
    assign o_entry_col   = r_oecol;
    assign o_entry_row   = r_oerow;

endmodule

### hdl/gaps_checker.sv
// Port-level checks of the grid path search unit, bound to the top level.
module gaps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_found,
    input logic [10:0] o_path_length,
    input logic        o_entry_valid,
    input logic [4:0]  o_entry_col,
    input logic [4:0]  o_entry_row
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_found) && $stable(o_path_length))
        else $error("result word changed while stalled");

    a_len_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_path_length != 11'd0) == o_found))
        else $error("path length disagrees with found");

    a_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_entry_valid |-> o_entry_col == 5'd0 && o_entry_row == 5'd0)
        else $error("entry fields set without a valid entry");

    a_entry_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_entry_valid |-> o_found)
        else $error("path entry given without a found path");

endmodule

bind grid_a_star_path_search_unit gaps_checker u_gaps_checker (.*);

### bench/grid_a_star_path_search_unit_test.sv
// Self-checking bench for the grid A* path search unit: cell writes, searches and path reads.
module grid_a_star_path_search_unit_test;
    import gaps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOL = 32;
    localparam int NROW = 32;
    localparam int NCELL = NCOL * NROW;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_mode;
    logic [4:0]  i_cell_col;
    logic [4:0]  i_cell_row;
    logic        i_blocked;
    logic [4:0]  i_start_x;
    logic [4:0]  i_start_y;
    logic [4:0]  i_goal_x;
    logic [4:0]  i_goal_y;
    logic [9:0]  i_path_index;
    logic        o_valid;
    logic        i_ready;
    logic        o_found;
    logic [10:0] o_path_length;
    logic        o_entry_valid;
    logic [4:0]  o_entry_col;
    logic [4:0]  o_entry_row;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [7:0]  i_cfg_data;

    grid_a_star_path_search_unit #(.MAX_COLUMNS(NCOL), .MAX_ROWS(NROW)) dut (.*);

    typedef struct packed {
        logic        found;
        logic [10:0] length;
        logic        ev;
        logic [4:0]  ecol;
        logic [4:0]  erow;
    } t_answer;

    // predictor state
    bit          blk_map[NCELL];
    logic [1:0]  stat_map[NCELL];
    logic [15:0] cost_map[NCELL];
    logic [2:0]  par_map[NCELL];
    logic [9:0]  route[NCELL];
    int unsigned route_len;
    bit          route_found;
    bit          p_diag;
    logic [7:0]  p_scost, p_dcost, p_weight;
    logic [5:0]  p_cols, p_rows;

    t_answer answer_q[$];
    int      errors;
    int      n_words, n_results, n_found;
    int      send_idle_pct, recv_stall_pct;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int dx_of(int d);
        case (d)
            0, 6, 7: return 1;
            1, 4, 5: return -1;
            default: return 0;
        endcase
    endfunction

    function automatic int dy_of(int d);
        case (d)
            2, 5, 7: return 1;
            3, 4, 6: return -1;
            default: return 0;
        endcase
    endfunction

    function automatic int dim_of(logic [5:0] v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int gap_of(int a, int b);
        return a > b ? a - b : b - a;
    endfunction

    task automatic predict_search(int sx, int sy, int gx, int gy);
        int cols, rows, start, goal, best, cur, n, ni, nx, ny, idx, d;
        int unsigned f, best_f, g;
        bit reached;
        cols = dim_of(p_cols, NCOL);
        rows = dim_of(p_rows, NROW);
        route_len = 0;
        route_found = 0;
        reached = 0;
        if (sx >= cols || sy >= rows || gx >= cols || gy >= rows) return;
        foreach (stat_map[i]) stat_map[i] = ST_UNVISITED;
        start = sy * NCOL + sx;
        goal = gy * NCOL + gx;
        stat_map[start] = ST_OPEN;
        cost_map[start] = 0;
        par_map[start] = 0;
        forever begin
            best = -1;
            best_f = 0;
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < cols; c++) begin
                    idx = r * NCOL + c;
                    if (stat_map[idx] != ST_OPEN) continue;
                    f = cost_map[idx] + p_weight * (gap_of(c, gx) + gap_of(r, gy));
                    if (best < 0 || f < best_f) begin
                        best = idx;
                        best_f = f;
                    end
                end
            end
            if (best < 0) break;
            stat_map[best] = ST_CLOSED;
            if (best == goal) begin
                reached = 1;
                break;
            end
            for (d = 0; d < (p_diag ? 8 : 4); d++) begin
                nx = best % NCOL + dx_of(d);
                ny = best / NCOL + dy_of(d);
                if (nx < 0 || ny < 0 || nx >= cols || ny >= rows) continue;
                ni = ny * NCOL + nx;
                if (blk_map[ni] || stat_map[ni] == ST_CLOSED) continue;
                g = cost_map[best] + (d < 4 ? p_scost : p_dcost);
                if (g > COST_MAX) g = COST_MAX;
                if (stat_map[ni] == ST_UNVISITED || g < cost_map[ni]) begin
                    stat_map[ni] = ST_OPEN;
                    cost_map[ni] = g[15:0];
                    par_map[ni] = d[2:0];
                end
            end
        end
        if (!reached) return;
        cur = goal;
        n = 1;
        while (cur != start && n < NCELL) begin
            cur -= dy_of(par_map[cur]) * NCOL + dx_of(par_map[cur]);
            if (cur < 0 || cur >= NCELL) return;
            n++;
        end
        cur = goal;
        for (int k = n - 1; k >= 0; k--) begin
            route[k] = cur[9:0];
            if (k > 0) cur -= dy_of(par_map[cur]) * NCOL + dx_of(par_map[cur]);
        end
        route_len = n;
        route_found = 1;
    endtask

    task automatic predict_word(t_mode m, int cc, int cr, bit b, int sx, int sy, int gx,
                                int gy, int pi);
        t_answer a;
        a = '0;
        case (m)
            MODE_WRITE: blk_map[cr * NCOL + cc] = b;
            MODE_SEARCH: predict_search(sx, sy, gx, gy);
            MODE_READ: begin
                if (pi < route_len) begin
                    a.ev = 1'b1;
                    a.ecol = 5'(route[pi] % NCOL);
                    a.erow = 5'(route[pi] / NCOL);
                end
            end
            default: ;
        endcase
        a.found = route_found;
        a.length = 11'(route_len);
        if (m == MODE_SEARCH && route_found) n_found++;
        answer_q = {answer_q, a};
    endtask

    task automatic send_word(t_mode m, int cc = 0, int cr = 0, bit b = 0, int sx = 0,
                             int sy = 0, int gx = 0, int gy = 0, int pi = 0);
        cc &= 31;
        cr &= 31;
        sx &= 31;
        sy &= 31;
        gx &= 31;
        gy &= 31;
        pi &= 1023;
        do begin
            @(posedge i_clk);
        end while ($urandom_range(99) < send_idle_pct);
        predict_word(m, cc, cr, b, sx, sy, gx, gy, pi);
        i_valid      <= 1'b1;
        i_mode       <= m;
        i_cell_col   <= 5'(cc);
        i_cell_row   <= 5'(cr);
        i_blocked    <= b;
        i_start_x    <= 5'(sx);
        i_start_y    <= 5'(sy);
        i_goal_x     <= 5'(gx);
        i_goal_y     <= 5'(gy);
        i_path_index <= 10'(pi);
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        i_valid <= 1'b0;
        n_words++;
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        while (answer_q.size() != 0 && guard < 4000000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [7:0] v);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_DIAG:   p_diag = v[0];
            CFG_SCOST:  p_scost = v;
            CFG_DCOST:  p_dcost = v;
            CFG_WEIGHT: p_weight = v;
            CFG_COLS:   p_cols = v[5:0];
            CFG_ROWS:   p_rows = v[5:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(int cols, int rows, int diag, int sc, int dc, int w);
        write_reg(CFG_COLS, 8'(cols));
        write_reg(CFG_ROWS, 8'(rows));
        write_reg(CFG_DIAG, 8'(diag));
        write_reg(CFG_SCOST, 8'(sc));
        write_reg(CFG_DCOST, 8'(dc));
        write_reg(CFG_WEIGHT, 8'(w));
    endtask

    task automatic read_whole_path();
        int len;
        len = route_len;
        for (int i = 0; i <= len; i++) send_word(MODE_READ, .pi(i));
    endtask

    task automatic test_directed();
        send_word(MODE_READ, .pi(0));
        send_word(MODE_NONE, 31, 31, 1'b1, 31, 31, 31, 31, 1023);
        set_grid(6, 5, 0, 10, 14, 10);
        send_word(MODE_SEARCH, .sx(2), .sy(2), .gx(2), .gy(2));
        read_whole_path();
        send_word(MODE_WRITE, .cc(2), .cr(0), .b(1'b1));
        send_word(MODE_WRITE, .cc(2), .cr(1), .b(1'b1));
        send_word(MODE_WRITE, .cc(2), .cr(2), .b(1'b1));
        send_word(MODE_WRITE, .cc(31), .cr(31), .b(1'b1));
        send_word(MODE_SEARCH, .sx(0), .sy(0), .gx(5), .gy(0));
        read_whole_path();
        send_word(MODE_READ, .pi(1023));
        send_word(MODE_SEARCH, .sx(6), .sy(0), .gx(0), .gy(0));
        send_word(MODE_SEARCH, .sx(2), .sy(1), .gx(2), .gy(1));
        send_word(MODE_SEARCH, .sx(0), .sy(0), .gx(2), .gy(1));
        send_word(MODE_SEARCH, .sx(0), .sy(4), .gx(0), .gy(31));
    endtask

    task automatic test_config_extremes();
        set_grid(0, 0, 1, 1, 1, 0);
        send_word(MODE_SEARCH, .sx(0), .sy(0), .gx(0), .gy(0));
        set_grid(4, 4, 1, 255, 255, 255);
        send_word(MODE_WRITE, .cc(1), .cr(0), .b(1'b1));
        send_word(MODE_WRITE, .cc(0), .cr(1), .b(1'b1));
        send_word(MODE_SEARCH, .sx(0), .sy(0), .gx(3), .gy(3));
        read_whole_path();
        set_grid(63, 40, 0, 255, 1, 0);
        send_word(MODE_SEARCH, .sx(31), .sy(31), .gx(29), .gy(31));
        send_word(MODE_WRITE, .cc(1), .cr(0), .b(1'b0));
        send_word(MODE_WRITE, .cc(0), .cr(1), .b(1'b0));
        send_word(MODE_WRITE, .cc(2), .cr(0), .b(1'b0));
        send_word(MODE_WRITE, .cc(2), .cr(1), .b(1'b0));
        send_word(MODE_WRITE, .cc(2), .cr(2), .b(1'b0));
        send_word(MODE_WRITE, .cc(31), .cr(31), .b(1'b0));
    endtask

    task automatic test_random(int count);
        int m, c, r;
        set_grid($urandom_range(3, 8), $urandom_range(3, 8), $urandom_range(1),
                 $urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(255));
        c = dim_of(p_cols, NCOL);
        r = dim_of(p_rows, NROW);
        for (int i = 0; i < count; i++) begin
            m = $urandom_range(99);
            if (m < 40)
                send_word(MODE_WRITE, $urandom_range(c - 1), $urandom_range(r - 1),
                          $urandom_range(99) < 30);
            else if (m < 45)
                send_word(MODE_WRITE, $urandom_range(31), $urandom_range(31),
                          1'($urandom_range(1)));
            else if (m < 65)
                send_word(MODE_SEARCH, .sx($urandom_range(c - 1)), .sy($urandom_range(r - 1)),
                          .gx($urandom_range(c - 1)), .gy($urandom_range(r - 1)));
            else if (m < 68)
                send_word(MODE_SEARCH, .sx($urandom_range(31)), .sy($urandom_range(31)),
                          .gx($urandom_range(31)), .gy($urandom_range(31)));
            else if (m < 95)
                send_word(MODE_READ, .pi($urandom_range(route_len + 1)));
            else
                send_word(m[0] ? MODE_NONE : MODE_READ, $urandom_range(31),
                          $urandom_range(31), 1'($urandom_range(1)), $urandom_range(31),
                          $urandom_range(31), $urandom_range(31), $urandom_range(31),
                          $urandom_range(1023));
        end
    endtask

    task automatic test_full_grid();
        set_grid(32, 32, 1, 10, 14, 10);
        send_word(MODE_SEARCH, .sx(0), .sy(0), .gx(31), .gy(31));
        send_word(MODE_READ, .pi(31));
        send_word(MODE_SEARCH, .sx(31), .sy(0), .gx(0), .gy(31));
        read_whole_path();
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected word: found=%0b len=%0d", $time, o_found,
                         o_path_length);
                errors++;
            end else begin
                t_answer a;
                a = answer_q.pop_front();
                if (a !== {o_found, o_path_length, o_entry_valid, o_entry_col, o_entry_row}) begin
                    $display("%0t: mismatch expected found=%0b len=%0d ev=%0b col=%0d row=%0d",
                             $time, a.found, a.length, a.ev, a.ecol, a.erow);
                    $display("%0t:          actual   found=%0b len=%0d ev=%0b col=%0d row=%0d",
                             $time, o_found, o_path_length, o_entry_valid, o_entry_col,
                             o_entry_row);
                    errors++;
                end
            end
        end
    end

    initial begin
        #3000ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_clk = 1'b0;
        errors = 0;
        n_words = 0;
        n_results = 0;
        n_found = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_mode = MODE_NONE;
        {i_cell_col, i_cell_row, i_blocked, i_start_x, i_start_y} = '0;
        {i_goal_x, i_goal_y, i_path_index} = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_DIAG;
        i_cfg_data = '0;
        foreach (blk_map[i]) blk_map[i] = 0;
        route_len = 0;
        route_found = 0;
        p_diag = 0;
        p_scost = 10;
        p_dcost = 14;
        p_weight = 10;
        p_cols = 32;
        p_rows = 32;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_config_extremes();
        test_random(6);
        drain_results();
        send_idle_pct = 68;
        test_random(6);
        send_idle_pct = 0;
        recv_stall_pct = 68;
        test_random(6);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        test_random(6);
        test_full_grid();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain_results();
        $display("covered %0d words, %0d results, %0d searches that reached the goal",
                 n_words, n_results, n_found);
        $display("over grid sizes from 1x1 to 32x32, both step sets and extreme costs");
        if (errors == 0 && answer_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
